### src/cdq_pkg.sv
// shared widths, operation codes and status codes for the circular deque
package cdq_pkg;

   localparam int WORD_W    = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int CAP_REG_W = 11;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic signed [WORD_W-1:0] word_type;

   localparam op_type OP_PUSH_FRONT = 2'd0;
   localparam op_type OP_PUSH_BACK  = 2'd1;
   localparam op_type OP_POP_FRONT  = 2'd2;
   localparam op_type OP_POP_REAR   = 2'd3;

   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_PUSH_FULL  = 2'd1;
   localparam status_type STATUS_POP_EMPTY  = 2'd2;

endpackage

### src/cdq_if.sv
// request and response channel interfaces of the circular deque

interface cdq_req_if;
   import cdq_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   word_type data_in;

   modport source (output valid, output operation, output data_in, input ready);
   modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;

   logic       valid;
   logic       ready;
   word_type   data_out;
   status_type status;
   logic       is_empty;
   logic       is_full;
   word_type   front_word;
   word_type   rear_word;

   modport source (output valid, output data_out, output status, output is_empty,
                   output is_full, output front_word, output rear_word, input ready);
   modport sink   (input valid, input data_out, input status, input is_empty,
                   input is_full, input front_word, input rear_word, output ready);
endinterface

### src/circular_double_ended_queue.sv
// circular double-ended queue top level with its word store
//
// Usage: each word on req_if carries an operation (push front, push back,
// pop front, pop rear) and a data word; each accepted word gives exactly one
// word on rsp_if with the popped data, a status, the empty/full flags and the
// words now at the front and rear.
// The store is a single-port-write, single-port-read memory of DEPTH words
// with registered read data. The front and rear words are also held in
// registers, so pushes, failed operations and pops that empty the deque
// finish without a store read. A pop that leaves entries behind reads the
// new end word from the store, and no new item is taken until it is back.
// Pushes go at one item per cycle while the output register is not stalled.
// The csr port writes the capacity (clamped to 1..DEPTH) and clears the
// deque; write it only while the block is idle.
// Reset clears the deque and sets the capacity to min(1024, DEPTH); no
// clearing pass runs, the store keeps stale words that are never reached.
// A stalled receiver holds the result in the output register; one new item
// is still accepted in the same cycle the pending result is taken.
module circular_double_ended_queue #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   cdq_req_if.sink                             req_if,
   cdq_rsp_if.source                           rsp_if,
   input  logic                                csr_write_enable,
   input  logic [cdq_pkg::CAP_REG_W-1:0]       csr_write_data
);
   import cdq_pkg::*;

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CAP_W     = $clog2(DEPTH + 1);
   localparam int CMP_W     = (CAP_W > CAP_REG_W) ? CAP_W : CAP_REG_W;
   localparam int CAP_RESET = (DEPTH < 1024) ? DEPTH : 1024;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   // control and status registers
   logic                state_ff, state_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [CAP_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    front_idx_ff, front_idx_in;
   logic [IDX_W-1:0]    rear_idx_ff, rear_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // cached end words and pending pop
   word_type            front_word_ff, front_word_in;
   word_type            rear_word_ff, rear_word_in;
   word_type            pend_data_ff, pend_data_in;
   logic                pend_front_ff, pend_front_in;

   // output register payload
   word_type            out_data_ff, out_data_in;
   status_type          out_status_ff, out_status_in;
   logic                out_empty_ff, out_empty_in;
   logic                out_full_ff, out_full_in;
   word_type            out_front_ff, out_front_in;
   word_type            out_rear_ff, out_rear_in;

   // store ports
   logic [WORD_W-1:0]   store_mem [DEPTH];
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_raddr;
   logic [WORD_W-1:0]   mem_rdata_ff;

   logic                accept;
   logic                rsp_load;
   logic                dq_empty;
   logic                dq_full;
   logic [CAP_W-1:0]    cap_minus_one;
   logic [IDX_W-1:0]    cap_last;
   logic [IDX_W-1:0]    front_dec;
   logic [IDX_W-1:0]    front_inc;
   logic [IDX_W-1:0]    rear_dec;
   logic [IDX_W-1:0]    rear_inc;
   logic [CMP_W-1:0]    csr_wide;
   logic [CAP_W-1:0]    csr_cap;

   // handshake
   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.data_out   = out_data_ff;
   assign rsp_if.status     = out_status_ff;
   assign rsp_if.is_empty   = out_empty_ff;
   assign rsp_if.is_full    = out_full_ff;
   assign rsp_if.front_word = out_front_ff;
   assign rsp_if.rear_word  = out_rear_ff;

   // ring index arithmetic
   assign dq_empty      = (count_ff == '0);
   assign dq_full       = (count_ff == cap_ff);
   assign cap_minus_one = cap_ff - CAP_W'(1);
   assign cap_last      = cap_minus_one[IDX_W-1:0];
   assign front_dec     = (front_idx_ff == '0) ? cap_last : front_idx_ff - IDX_W'(1);
   assign front_inc     = (front_idx_ff == cap_last) ? '0 : front_idx_ff + IDX_W'(1);
   assign rear_dec      = (rear_idx_ff == '0) ? cap_last : rear_idx_ff - IDX_W'(1);
   assign rear_inc      = (rear_idx_ff == cap_last) ? '0 : rear_idx_ff + IDX_W'(1);

   // capacity clamp to 1..DEPTH
   assign csr_wide = CMP_W'(csr_write_data);
   always_comb begin
      if (csr_write_data == '0) begin
         csr_cap = CAP_W'(1);
      end else if (csr_wide > CMP_W'(DEPTH)) begin
         csr_cap = CAP_W'(DEPTH);
      end else begin
         csr_cap = csr_wide[CAP_W-1:0];
      end
   end

   // sequencer and next state
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      front_idx_in  = front_idx_ff;
      rear_idx_in   = rear_idx_ff;
      front_word_in = front_word_ff;
      rear_word_in  = rear_word_ff;
      pend_data_in  = pend_data_ff;
      pend_front_in = pend_front_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = req_if.data_in;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      rsp_load      = 1'b0;
      out_data_in   = '0;
      out_status_in = STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_if.operation) inside
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     rsp_load = 1'b1;
                     if (dq_full) begin
                        out_status_in = STATUS_PUSH_FULL;
                     end else if (dq_empty) begin
                        mem_we        = 1'b1;
                        front_idx_in  = '0;
                        rear_idx_in   = '0;
                        front_word_in = req_if.data_in;
                        rear_word_in  = req_if.data_in;
                        count_in      = count_ff + CAP_W'(1);
                     end else if (req_if.operation == OP_PUSH_FRONT) begin
                        mem_we        = 1'b1;
                        mem_waddr     = front_dec;
                        front_idx_in  = front_dec;
                        front_word_in = req_if.data_in;
                        count_in      = count_ff + CAP_W'(1);
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = rear_inc;
                        rear_idx_in   = rear_inc;
                        rear_word_in  = req_if.data_in;
                        count_in      = count_ff + CAP_W'(1);
                     end
                  end
                  default: begin
                     pend_front_in = (req_if.operation == OP_POP_FRONT);
                     pend_data_in  = pend_front_in ? front_word_ff : rear_word_ff;
                     if (dq_empty) begin
                        rsp_load      = 1'b1;
                        out_status_in = STATUS_POP_EMPTY;
                     end else if (count_ff == CAP_W'(1)) begin
                        // last entry leaves: indices go home
                        rsp_load     = 1'b1;
                        out_data_in  = pend_data_in;
                        count_in     = '0;
                        front_idx_in = '0;
                        rear_idx_in  = '0;
                     end else begin
                        // fetch the new end word from the store
                        count_in = count_ff - CAP_W'(1);
                        mem_re   = 1'b1;
                        state_in = ST_READ;
                        if (pend_front_in) begin
                           front_idx_in = front_inc;
                           mem_raddr    = front_inc;
                        end else begin
                           rear_idx_in = rear_dec;
                           mem_raddr   = rear_dec;
                        end
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            out_data_in = pend_data_ff;
            state_in    = ST_IDLE;
            if (pend_front_ff) begin
               front_word_in = mem_rdata_ff;
            end else begin
               rear_word_in = mem_rdata_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write clears the deque
      if (csr_write_enable) begin
         cap_in       = csr_cap;
         count_in     = '0;
         front_idx_in = '0;
         rear_idx_in  = '0;
      end
   end

   // result word built from the state after the item
   assign out_empty_in = (count_in == '0);
   assign out_full_in  = (count_in == cap_ff);
   assign out_front_in = out_empty_in ? '0 : front_word_in;
   assign out_rear_in  = out_empty_in ? '0 : rear_word_in;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_W'(CAP_RESET);
         count_ff     <= '0;
         front_idx_ff <= '0;
         rear_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         front_idx_ff <= front_idx_in;
         rear_idx_ff  <= rear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      rear_word_ff  <= rear_word_in;
      pend_data_ff  <= pend_data_in;
      pend_front_ff <= pend_front_in;
      if (rsp_load) begin
         out_data_ff   <= out_data_in;
         out_status_ff <= out_status_in;
         out_empty_ff  <= out_empty_in;
         out_full_ff   <= out_full_in;
         out_front_ff  <= out_front_in;
         out_rear_ff   <= out_rear_in;
      end
   end

   // word store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_raddr];
      end
   end

   // checks
   a_count_in_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("entry count above capacity");

   a_empty_indices_home: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (front_idx_ff == '0 && rear_idx_ff == '0))
      else $error("empty deque with indices away from entry zero");

   a_single_entry_ends_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CAP_W'(1)) |-> (front_idx_ff == rear_idx_ff))
      else $error("single entry but front and rear differ");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("output register busy while a pop read completes");

   a_read_then_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("pop read did not produce a result");

endmodule

### dv/tb_circular_double_ended_queue.sv
// self-checking testbench for the circular double-ended queue
module tb_circular_double_ended_queue;
   import cdq_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int CLK_PERIOD   = 12;
   localparam int DRAIN_LIMIT  = 5000;

   typedef struct {
      word_type   data_out;
      status_type status;
      logic       is_empty;
      logic       is_full;
      word_type   front_word;
      word_type   rear_word;
   } deque_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CAP_REG_W-1:0] csr_write_data;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_double_ended_queue #(
      .DEPTH (DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the deque
   word_type             shadow_store [DEPTH];
   int unsigned          head_pos   = 0;
   int unsigned          tail_pos   = 0;
   int unsigned          fill_count = 0;
   logic [CAP_REG_W-1:0] capacity_reg = CAP_REG_W'(1024);

   deque_result_type pending_results [$];

   int send_idle_pct  = 6;
   int recv_idle_pct  = 46;
   int words_sent     = 0;
   int words_checked  = 0;
   int mismatches     = 0;
   int dropped_pushes = 0;
   int empty_pops     = 0;

   // clock
   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // usable ring size: zero counts as one, saturates at the store depth
   function automatic int unsigned effective_capacity();
      if (capacity_reg == '0) return 1;
      if (capacity_reg > DEPTH) return DEPTH;
      return int'(capacity_reg);
   endfunction

   // apply one operation to the shadow deque and return the expected word
   function automatic deque_result_type apply_deque_op(op_type op, word_type word);
      int unsigned      cap;
      deque_result_type res;
      cap = effective_capacity();
      res.data_out = '0;
      res.status   = STATUS_OK;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (fill_count >= cap) begin
            res.status = STATUS_PUSH_FULL;
            dropped_pushes++;
         end else begin
            if (fill_count == 0) begin
               head_pos = 0;
               tail_pos = 0;
               shadow_store[0] = word;
            end else if (op == OP_PUSH_FRONT) begin
               head_pos = (head_pos == 0) ? cap - 1 : head_pos - 1;
               shadow_store[head_pos] = word;
            end else begin
               tail_pos = (tail_pos + 1 >= cap) ? 0 : tail_pos + 1;
               shadow_store[tail_pos] = word;
            end
            fill_count++;
         end
      end else begin
         if (fill_count == 0) begin
            res.status = STATUS_POP_EMPTY;
            empty_pops++;
         end else begin
            if (op == OP_POP_FRONT) begin
               res.data_out = shadow_store[head_pos];
               head_pos = (head_pos + 1 >= cap) ? 0 : head_pos + 1;
            end else begin
               res.data_out = shadow_store[tail_pos];
               tail_pos = (tail_pos == 0) ? cap - 1 : tail_pos - 1;
            end
            fill_count--;
            // an emptied deque restarts at entry 0
            if (fill_count == 0) begin
               head_pos = 0;
               tail_pos = 0;
            end
         end
      end
      res.is_empty   = (fill_count == 0);
      res.is_full    = (fill_count == cap);
      res.front_word = (fill_count == 0) ? '0 : shadow_store[head_pos];
      res.rear_word  = (fill_count == 0) ? '0 : shadow_store[tail_pos];
      return res;
   endfunction

   function automatic op_type random_op(int push_pct);
      logic front_end;
      front_end = 1'($urandom_range(1));
      if ($urandom_range(99) < push_pct)
         return front_end ? OP_PUSH_FRONT : OP_PUSH_BACK;
      return front_end ? OP_POP_FRONT : OP_POP_REAR;
   endfunction

   // drive one request word, wait for its handshake, queue its expectation
   task automatic send_word(op_type op, word_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.data_in   <= word;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.push_back(apply_deque_op(op, word));
      words_sent++;
   endtask

   // stop sending and wait until every response is back or the drain limit runs out
   task automatic wait_for_drain();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $display("%0t: responses missing, expected %0d more, actual 0",
                  $time, pending_results.size());
         mismatches += pending_results.size();
         pending_results.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   // capacity write while idle; it also clears the deque
   task automatic write_capacity(logic [CAP_REG_W-1:0] value);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_reg = value;
      head_pos     = 0;
      tail_pos     = 0;
      fill_count   = 0;
   endtask

   function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b0;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b1;
   endfunction

   // response checker and receiver stalls
   initial begin : response_checker
      deque_result_type want;
      bit               bad;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response word with nothing pending, expected none, actual %h",
                        $time, rsp_bus.data_out);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               words_checked++;
               bad = 1'b0;
               bad |= field_differs("data_out", want.data_out, rsp_bus.data_out);
               bad |= field_differs("status", 32'(want.status), 32'(rsp_bus.status));
               bad |= field_differs("is_empty", 32'(want.is_empty), 32'(rsp_bus.is_empty));
               bad |= field_differs("is_full", 32'(want.is_full), 32'(rsp_bus.is_full));
               bad |= field_differs("front_word", want.front_word, rsp_bus.front_word);
               bad |= field_differs("rear_word", want.rear_word, rsp_bus.rear_word);
               if (bad) mismatches++;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // pops on an empty deque straight out of reset
   task automatic test_empty_after_reset();
      send_word(OP_POP_FRONT, word_type'(32'h1234_5678));
      send_word(OP_POP_REAR, word_type'(32'hFFFF_FFFF));
   endtask

   // extreme words at both ends, wrap of the front index below entry 0
   task automatic test_push_pop_extremes();
      send_word(OP_PUSH_BACK, word_type'(32'h7FFF_FFFF));
      send_word(OP_PUSH_FRONT, word_type'(32'h8000_0000));
      send_word(OP_PUSH_BACK, word_type'(32'h0000_0000));
      send_word(OP_PUSH_FRONT, word_type'(32'hFFFF_FFFF));
      send_word(OP_POP_REAR, '0);
      send_word(OP_POP_FRONT, '0);
      send_word(OP_POP_FRONT, '0);
      send_word(OP_POP_REAR, '0);
      // deque just went empty: next push restarts at entry 0
      send_word(OP_PUSH_FRONT, word_type'(32'h5555_5555));
      send_word(OP_PUSH_BACK, word_type'(32'hAAAA_AAAA));
      send_word(OP_POP_FRONT, '0);
      send_word(OP_POP_FRONT, '0);
   endtask

   // capacity zero behaves as a single entry
   task automatic test_capacity_floor();
      write_capacity('0);
      send_word(OP_PUSH_FRONT, word_type'(32'h0000_0001));
      send_word(OP_PUSH_BACK, word_type'(32'h0000_0002));
      send_word(OP_POP_FRONT, '0);
      send_word(OP_POP_REAR, '0);
   endtask

   // three-entry ring: full drop and wrap of the rear index both ways
   task automatic test_wrap_three();
      write_capacity(CAP_REG_W'(3));
      send_word(OP_PUSH_BACK, word_type'(32'h0000_00A1));
      send_word(OP_PUSH_BACK, word_type'(32'h0000_00B2));
      send_word(OP_PUSH_BACK, word_type'(32'h0000_00C3));
      send_word(OP_PUSH_FRONT, word_type'(32'h0000_00D4));
      send_word(OP_POP_FRONT, '0);
      send_word(OP_PUSH_BACK, word_type'(32'h0000_00E5));
      send_word(OP_POP_REAR, '0);
      send_word(OP_POP_REAR, '0);
   endtask

   // random traffic over a spread of capacities, pushes and pops in turns
   task automatic test_random_capacities(int segments);
      int                   n;
      int                   push_pct;
      logic [CAP_REG_W-1:0] cap;
      for (int seg = 0; seg < segments; seg++) begin
         case ($urandom_range(9))
            0:       cap = CAP_REG_W'(1);
            1:       cap = CAP_REG_W'(2);
            2:       cap = CAP_REG_W'($urandom_range(3, 8));
            8:       cap = CAP_REG_W'($urandom_range(25, 200));
            9:       cap = CAP_REG_W'($urandom_range(1025, 2047));
            default: cap = CAP_REG_W'($urandom_range(2, 24));
         endcase
         write_capacity(cap);
         n = $urandom_range(20, 60);
         for (int j = 0; j < n; j++) begin
            push_pct = ((j / 10) % 2 == 0) ? 70 : 30;
            send_word(random_op(push_pct), word_type'($urandom()));
         end
      end
   endtask

   // oversized capacity saturates to the full store: fill it and overrun
   task automatic test_fill_saturated();
      write_capacity(CAP_REG_W'(2047));
      for (int i = 0; i < DEPTH + 2; i++)
         send_word(random_op(100), word_type'($urandom()));
      for (int i = 0; i < 30; i++)
         send_word(random_op(40), word_type'($urandom()));
   endtask

   // exact store-depth capacity with mostly pushes
   task automatic test_capacity_exact_depth();
      write_capacity(CAP_REG_W'(DEPTH));
      for (int i = 0; i < 80; i++)
         send_word(random_op(60), word_type'($urandom()));
   endtask

   // stimulus sequence
   initial begin : stimulus
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_PUSH_FRONT;
      req_bus.data_in   <= '0;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 46;
      test_empty_after_reset();
      test_push_pop_extremes();
      test_capacity_floor();
      test_wrap_three();
      test_random_capacities(3);

      send_idle_pct = 46;
      recv_idle_pct = 6;
      test_fill_saturated();
      test_random_capacities(2);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_capacity_exact_depth();
      test_random_capacities(2);

      wait_for_drain();
      $display("covered %0d requests and %0d responses, capacities 0 to 2047",
               words_sent, words_checked);
      $display("%0d pushes dropped on a full deque, %0d pops on an empty one",
               dropped_pushes, empty_pops);
      if (mismatches == 0) begin
         $display("tb_circular_double_ended_queue OK");
      end else begin
         $display("tb_circular_double_ended_queue NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(CLK_PERIOD * 400000);
      $display("%0t: timeout", $time);
      $display("tb_circular_double_ended_queue NOT OK");
      $finish;
   end

endmodule
